// ===== hw/rtl/psud_pkg.sv =====
// ---------------------------------------------------------------------------
// psud_pkg
// shared codes and controller/datapath interface types for the prime stepper
// ---------------------------------------------------------------------------
package psud_pkg;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_NEXT  = 2'd1;
  localparam logic [1:0] MODE_PREV  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;   // unused, value kept

  localparam int unsigned IO_WIDTH = 16;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic set_load;
    logic set_keep;
    logic set_one;
    logic set_cand;
    logic set_flag;
    logic cand_init_up;
    logic cand_init_down;
    logic cand_inc;
    logic cand_dec;
    logic test_init;
    logic d_step;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       cand_over;
    logic       cand_le2;
    logic       cand_lt2;
    logic       sq_gt_cand;
    logic       div_done;
    logic       rem_zero;
  } dp_sts_t;

endpackage

// ===== hw/rtl/prime_step_up_down_unit.sv =====
// ---------------------------------------------------------------------------
// prime_step_up_down_unit
// next / previous prime stepper using trial division
// ---------------------------------------------------------------------------
// timing: a load runs capture and dispatch, then the result strobe; a step is
//   data dependent, one serial division per trial divisor, up to sqrt(candidate)
//   divisors per candidate, over every candidate up to the next or previous prime
// throughput: one word at a time, busy high through the result cycle
// reset: synchronous, held value returns to 1; the result strobe done is
//   high for one cycle and the receiver cannot stall it
// ---------------------------------------------------------------------------
module prime_step_up_down_unit #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [15:0] load_value,
  output logic        done,
  output logic [15:0] old_value,
  output logic [15:0] new_value,
  output logic        overflow
);

  psud_pkg::ctrl_cmd_t    cmd;
  psud_pkg::dp_sts_t      sts;
  logic [VALUE_WIDTH-1:0] load_w;
  logic [VALUE_WIDTH-1:0] old_w;
  logic [VALUE_WIDTH-1:0] new_w;

  // fit the fixed 16-bit word ports to the internal value width
  generate
    if (VALUE_WIDTH >= psud_pkg::IO_WIDTH) begin : g_wide
      assign load_w    = VALUE_WIDTH'(load_value);
      assign old_value = old_w[15:0];
      assign new_value = new_w[15:0];
    end else begin : g_narrow
      assign load_w    = load_value[VALUE_WIDTH-1:0];
      assign old_value = 16'(old_w);
      assign new_value = 16'(new_w);
    end
  endgenerate

  // controller: sequences load / step and the candidate search
  psud_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath: held value, candidate and trial division
  psud_dp #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .mode   (mode),
    .load_w (load_w),
    .old_w  (old_w),
    .new_w  (new_w),
    .flag   (overflow)
  );

endmodule

// ===== hw/rtl/psud_div.sv =====
// ---------------------------------------------------------------------------
// psud_div
// bit-serial restoring remainder unit, one dividend bit per cycle
// ---------------------------------------------------------------------------
module psud_div #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic                   rem_zero
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic                   running;
  logic [CntW-1:0]        cnt;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] shreg;
  logic [VALUE_WIDTH-1:0] dvs;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  assign trial = {rem, shreg[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CntW'(VALUE_WIDTH);
      end else if (running) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
      dvs   <= divisor;
    end else if (running) begin
      shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= diff[VALUE_WIDTH-1:0];
      end else begin
        rem <= trial[VALUE_WIDTH-1:0];
      end
    end
  end

  assign rem_zero = (rem == '0);

endmodule

// ===== hw/rtl/psud_dp.sv =====
// ---------------------------------------------------------------------------
// psud_dp
// datapath: held value, candidate, trial divisor and its square
// ---------------------------------------------------------------------------
module psud_dp #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  psud_pkg::ctrl_cmd_t    cmd,
  output psud_pkg::dp_sts_t      sts,
  input  logic [1:0]             mode,
  input  logic [VALUE_WIDTH-1:0] load_w,
  output logic [VALUE_WIDTH-1:0] old_w,
  output logic [VALUE_WIDTH-1:0] new_w,
  output logic                   flag
);

  logic [VALUE_WIDTH-1:0] held;
  logic [VALUE_WIDTH-1:0] old_r;
  logic [VALUE_WIDTH-1:0] new_r;
  logic [VALUE_WIDTH-1:0] load_r;
  logic [1:0]             mode_r;
  logic [VALUE_WIDTH:0]   cand;
  logic [VALUE_WIDTH-1:0] dvs;
  logic [VALUE_WIDTH+1:0] sq;
  logic                   div_done;
  logic                   rem_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= VALUE_WIDTH'(1);
    end else if (cmd.commit) begin
      held <= new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      old_r  <= held;
      mode_r <= mode;
      load_r <= load_w;
      flag   <= 1'b0;
    end
    if (cmd.set_flag) flag <= 1'b1;

    if (cmd.set_load) begin
      new_r <= load_r;
    end else if (cmd.set_keep) begin
      new_r <= old_r;
    end else if (cmd.set_one) begin
      new_r <= VALUE_WIDTH'(1);
    end else if (cmd.set_cand) begin
      new_r <= cand[VALUE_WIDTH-1:0];
    end

    if (cmd.cand_init_up) begin
      cand <= {1'b0, old_r} + (VALUE_WIDTH+1)'(1);
    end else if (cmd.cand_init_down) begin
      cand <= {1'b0, old_r};
    end else if (cmd.cand_inc) begin
      cand <= cand + (VALUE_WIDTH+1)'(1);
    end else if (cmd.cand_dec) begin
      cand <= cand - (VALUE_WIDTH+1)'(1);
    end

    // (d+1)^2 = d^2 + 2d + 1
    if (cmd.test_init) begin
      dvs <= VALUE_WIDTH'(2);
      sq  <= (VALUE_WIDTH+2)'(4);
    end else if (cmd.d_step) begin
      dvs <= dvs + VALUE_WIDTH'(1);
      sq  <= sq + (VALUE_WIDTH+2)'({dvs, 1'b1});
    end
  end

  psud_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cand[VALUE_WIDTH-1:0]),
    .divisor  (dvs),
    .done     (div_done),
    .rem_zero (rem_zero)
  );

  always_comb begin
    sts.mode       = mode_r;
    sts.cand_over  = cand[VALUE_WIDTH];
    sts.cand_le2   = (cand <= (VALUE_WIDTH+1)'(2));
    sts.cand_lt2   = (cand < (VALUE_WIDTH+1)'(2));
    sts.sq_gt_cand = (sq > {1'b0, cand});
    sts.div_done   = div_done;
    sts.rem_zero   = rem_zero;
  end

  assign old_w = old_r;
  assign new_w = new_r;

endmodule

// ===== hw/rtl/psud_ctrl.sv =====
// ---------------------------------------------------------------------------
// psud_ctrl
// controller: sequences candidate search and trial division
// ---------------------------------------------------------------------------
module psud_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  psud_pkg::dp_sts_t   sts,
  output psud_pkg::ctrl_cmd_t cmd,
  output logic                busy,
  output logic                done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_NEXT_CHECK,
    ST_PREV_CHECK,
    ST_TEST_INIT,
    ST_TEST_CHECK,
    ST_DIV_WAIT,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_reject;

  // where a rejected candidate goes
  assign after_reject = (sts.mode == psud_pkg::MODE_NEXT) ? ST_NEXT_CHECK : ST_PREV_CHECK;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.mode)
          psud_pkg::MODE_LOAD: begin
            cmd.set_load = 1'b1;
            state_next   = ST_RESULT;
          end
          psud_pkg::MODE_NEXT: begin
            cmd.cand_init_up = 1'b1;
            state_next       = ST_NEXT_CHECK;
          end
          psud_pkg::MODE_PREV: begin
            cmd.cand_init_down = 1'b1;
            state_next         = ST_PREV_CHECK;
          end
          default: begin
            cmd.set_keep = 1'b1;
            state_next   = ST_RESULT;
          end
        endcase
      end
      ST_NEXT_CHECK: begin
        if (sts.cand_over) begin
          cmd.set_keep = 1'b1;
          cmd.set_flag = 1'b1;
          state_next   = ST_RESULT;
        end else begin
          state_next = ST_TEST_INIT;
        end
      end
      ST_PREV_CHECK: begin
        if (sts.cand_le2) begin
          cmd.set_one = 1'b1;
          state_next  = ST_RESULT;
        end else begin
          cmd.cand_dec = 1'b1;
          state_next   = ST_TEST_INIT;
        end
      end
      ST_TEST_INIT: begin
        cmd.test_init = 1'b1;
        state_next    = ST_TEST_CHECK;
      end
      ST_TEST_CHECK: begin
        if (sts.cand_lt2) begin
          cmd.cand_inc = (sts.mode == psud_pkg::MODE_NEXT);
          state_next   = after_reject;
        end else if (sts.sq_gt_cand) begin
          cmd.set_cand = 1'b1;
          state_next   = ST_RESULT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.cand_inc = (sts.mode == psud_pkg::MODE_NEXT);
            state_next   = after_reject;
          end else begin
            cmd.d_step = 1'b1;
            state_next = ST_TEST_CHECK;
          end
        end
      end
      ST_RESULT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
      done  <= (state_next == ST_RESULT);
    end
  end

endmodule
